/* rtl/tile_hash_shard_select_top_macros.svh */
// Assertion macros for the tile hash shard select block
`ifndef TILE_HASH_SHARD_SELECT_TOP_MACROS_SVH
`define TILE_HASH_SHARD_SELECT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define THS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define THS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/ths_pkg.sv */
// Shared types and constants for the tile hash shard select block
package ths_pkg;

  localparam int COORD_W        = 32;
  localparam int COLS_W         = 32;
  localparam int SCOUNT_W       = 13;
  localparam int SHARD_W        = 12;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_SHARDS = 4096;
  localparam int TILE_SHIFT     = 3;
  localparam int HASH_W         = 64;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS = 1'b0,
    REG_SHARD_COUNT  = 1'b1
  } cfg_reg_e;

endpackage

/* rtl/ths_divpipe.sv */
// Pipelined restoring divider, one quotient bit per stage
module ths_divpipe
  import ths_pkg::*;
#(
  parameter int N = 32,
  parameter int D = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         valid_o,
  output logic [N-1:0] quot_o,
  output logic [D-1:0] rem_o
);

  logic         vld_q [1:N];
  logic [D-1:0] rem_q [1:N];
  logic [N-1:0] num_q [1:N];

  logic         vld_in [0:N-1];
  logic [D-1:0] rem_in [0:N-1];
  logic [N-1:0] num_in [0:N-1];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [D:0] trial;
    logic       ge;

    if (i == 0) begin : g_first
      assign vld_in[0] = valid_i;
      assign rem_in[0] = '0;
      assign num_in[0] = dividend_i;
    end else begin : g_next
      assign vld_in[i] = vld_q[i];
      assign rem_in[i] = rem_q[i];
      assign num_in[i] = num_q[i];
    end

    assign trial = {rem_in[i], num_in[i][N-1]};
    assign ge    = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= ge ? D'(trial - {1'b0, divisor_i}) : trial[D-1:0];
        num_q[i+1] <= {num_in[i][N-2:0], ge};
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quot_o  = num_q[N];
  assign rem_o   = rem_q[N];

endmodule

/* rtl/ths_tile.sv */
// Tile index from row and column: two stages, multiply then add
module ths_tile
  import ths_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COLS_W-1:0]  col_i,
  input  logic [COLS_W-1:0]  cols_i,
  output logic              valid_o,
  output logic [HASH_W-1:0] tile_o
);

  localparam int RT_W  = COORD_W - TILE_SHIFT;
  localparam int CT_W  = COLS_W - TILE_SHIFT;
  localparam int TPR_W = COLS_W + 1 - TILE_SHIFT;
  localparam int PR_W  = RT_W + TPR_W;

  logic [COLS_W:0]   cols_sum;
  logic [TPR_W-1:0]  tiles_per_row;
  logic [PR_W-1:0]   prod_d;
  logic [PR_W-1:0]   prod_q;
  logic [CT_W-1:0]   colt_q;
  logic [HASH_W-1:0] tile_q;
  logic              vld_a_q, vld_b_q;

  // ceil(cols / 8)
  assign cols_sum      = {1'b0, cols_i} + (COLS_W+1)'(7);
  assign tiles_per_row = cols_sum[COLS_W:TILE_SHIFT];
  assign prod_d        = PR_W'(row_i[COORD_W-1:TILE_SHIFT]) * PR_W'(tiles_per_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      colt_q <= col_i[COLS_W-1:TILE_SHIFT];
      tile_q <= HASH_W'(prod_q) + HASH_W'(colt_q);
    end
  end

  assign valid_o = vld_b_q;
  assign tile_o  = tile_q;

endmodule

/* rtl/ths_mix.sv */
// 64-bit golden step and finalizer, multiplies split into 32-bit partials
module ths_mix
  import ths_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [HASH_W-1:0] tile_i,
  output logic              valid_o,
  output logic [HASH_W-1:0] hash_o
);

  logic [5:0]  vld_q;
  logic [63:0] v1_q, x, y, m_q, s_q, h_q;
  logic [63:0] pa0_q, pb0_q;
  logic [31:0] pa1_q, pa2_q, pb1_q, pb2_q;

  assign x = v1_q ^ (v1_q >> 30);
  assign y = m_q ^ (m_q >> 27);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q  <= tile_i + GOLDEN_STEP;
      // low 64 bits of x * A
      pa0_q <= 64'(x[31:0]) * 64'(MIX_MUL_A[31:0]);
      pa1_q <= 32'(x[31:0] * MIX_MUL_A[63:32]);
      pa2_q <= 32'(x[63:32] * MIX_MUL_A[31:0]);
      m_q   <= pa0_q + {pa1_q + pa2_q, 32'd0};
      // low 64 bits of y * B
      pb0_q <= 64'(y[31:0]) * 64'(MIX_MUL_B[31:0]);
      pb1_q <= 32'(y[31:0] * MIX_MUL_B[63:32]);
      pb2_q <= 32'(y[63:32] * MIX_MUL_B[31:0]);
      s_q   <= pb0_q + {pb1_q + pb2_q, 32'd0};
      h_q   <= s_q ^ (s_q >> 31);
    end
  end

  assign valid_o = vld_q[5];
  assign hash_o  = h_q;

endmodule

/* rtl/tile_hash_shard_select_top.sv */
// Top level of the tile hash shard select block
//
// Maps a 32-bit row-major grid coordinate to a shard index. One word in on
// the coordinate channel gives exactly one word out on the shard channel,
// in order. Both channels use valid/stall; a word moves on a clock edge with
// valid high and stall low.
// Throughput: one word per cycle, no gaps, while the output is not stalled.
// Pipeline: 104 register stages: 32 stages of the row/column divider (one
// quotient bit each), 2 tile stages, 6 hash stages and 64 stages of the
// shard modulo (one hash bit each).
// The whole pipe advances together; a stalled output holds its word and
// freezes every stage, bubbles included, so in_stall_o rises exactly when
// out_valid_o is high and out_stall_i is set.
// Reset (rst_ni low, async) empties the pipe and sets both registers to 1.
// Register writes (cfg_we_i) take effect at once; write them only when the
// pipe is empty. Index 0 is grid_columns, index 1 is shard_count; a count of
// zero acts as one, a shard count above MAX_SHARDS acts as MAX_SHARDS.
module tile_hash_shard_select_top
  import ths_pkg::*;
#(
  parameter int MAX_SHARDS = DEF_MAX_SHARDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_W-1:0]    coordinate_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SHARD_W-1:0]    shard_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // divisor width for the shard modulo
  localparam int SW = $clog2(MAX_SHARDS + 1);

  logic [COLS_W-1:0]   grid_columns_q;
  logic [SCOUNT_W-1:0] shard_count_q;
  logic [COLS_W-1:0]   cols_eff;
  logic [SW-1:0]       shards_eff;
  logic                en;

  logic                div_vld, tile_vld, mix_vld;
  logic [COORD_W-1:0]  row;
  logic [COLS_W-1:0]   col;
  logic [HASH_W-1:0]   tile, hash;
  logic [SW-1:0]       shard_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= COLS_W'(1);
      shard_count_q  <= SCOUNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_COLUMNS: grid_columns_q <= cfg_data_i[COLS_W-1:0];
        REG_SHARD_COUNT:  shard_count_q  <= cfg_data_i[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cols_eff = (grid_columns_q == '0) ? COLS_W'(1) : grid_columns_q;

  always_comb begin
    if (shard_count_q == '0) begin
      shards_eff = SW'(1);
    end else if (32'(shard_count_q) > MAX_SHARDS) begin
      shards_eff = SW'(MAX_SHARDS);
    end else begin
      shards_eff = SW'(shard_count_q);
    end
  end

  // global advance: the last stage is the output register
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  ths_divpipe #(
    .N (COORD_W),
    .D (COLS_W)
  ) u_rowcol (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .dividend_i (coordinate_i),
    .divisor_i  (cols_eff),
    .valid_o    (div_vld),
    .quot_o     (row),
    .rem_o      (col)
  );

  ths_tile u_tile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .row_i   (row),
    .col_i   (col),
    .cols_i  (cols_eff),
    .valid_o (tile_vld),
    .tile_o  (tile)
  );

  ths_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tile_vld),
    .tile_i  (tile),
    .valid_o (mix_vld),
    .hash_o  (hash)
  );

  // quotient of the hash is not needed, only the remainder
  ths_divpipe #(
    .N (HASH_W),
    .D (SW)
  ) u_shard_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (mix_vld),
    .dividend_i (hash),
    .divisor_i  (shards_eff),
    .valid_o    (out_valid_o),
    .quot_o     (),
    .rem_o      (shard_rem)
  );

  assign shard_o = SHARD_W'(shard_rem);

endmodule

/* rtl/ths_checker.sv */
// Port-level checks for the tile hash shard select block, with bind
`include "tile_hash_shard_select_top_macros.svh"

module ths_checker
  import ths_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [COORD_W-1:0]    coordinate_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [SHARD_W-1:0]    shard_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // held output word stays put
  `THS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(shard_o), "stalled output word changed")

  // input stalls only behind a stalled, valid output
  `THS_ASSERT_NOW(a_stall_cause, in_stall_o,
    out_valid_o && out_stall_i, "input stalled without output back-pressure")

  // a valid output word carries known bits
  `THS_ASSERT_NOW(a_known_out, out_valid_o,
    !$isunknown(shard_o), "output word has unknown bits")

endmodule

bind tile_hash_shard_select_top ths_checker u_ths_checker (.*);
